// ----- design/egdrp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and defaults of the ghost-debt refresh policy unit.
package egdrp_pkg;

    localparam int DISPLAY_W_DEF = 540;
    localparam int DISPLAY_H_DEF = 960;
    localparam int TILE_SIZE_DEF = 32;
    localparam int TILES_X_DEF   = 17;
    localparam int TILES_Y_DEF   = 30;

    localparam logic [7:0] LIMIT_RST = 8'd16;

    localparam logic [2:0] KIND_INVAL = 3'd0;
    localparam logic [2:0] KIND_FLUSH = 3'd1;
    localparam logic [2:0] KIND_TEXT  = 3'd2;
    localparam logic [2:0] KIND_FULL  = 3'd3;
    localparam logic [2:0] KIND_GHOST = 3'd4;

    localparam logic [1:0] INTENT_CLEAN = 2'd0;
    localparam logic [1:0] INTENT_ANIM  = 2'd1;
    localparam logic [1:0] INTENT_TEXT  = 2'd2;

    // signed box coordinate, wide enough for tile pixel positions
    typedef logic signed [14:0] t_crd;

    typedef enum logic [2:0] {
        MODE_GC16 = 3'd0,
        MODE_GL16 = 3'd1,
        MODE_DU4  = 3'd2,
        MODE_DU   = 3'd3,
        MODE_A2   = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        WOP_TEST  = 2'd0,
        WOP_ADD   = 2'd1,
        WOP_CLEAR = 2'd2,
        WOP_SCAN  = 2'd3
    } t_wop;

    typedef struct packed {
        logic  load;
        logic  align;
        logic  clip;
        logic  merge;
        logic  walk_start;
        t_wop  wop;
        logic  mode_we;
        t_mode mode;
        logic  push_set;
        logic  ghost_load;
        logic  dirty_clear;
        logic  dirty_text;
        logic  finish;
    } t_cmd;

    typedef struct packed {
        logic       clr_busy;
        logic       walk_done;
        logic [2:0] kind;
        logic [1:0] intent;
        logic       dirty_empty;
        logic       area_empty;
        logic       big;
        logic       hit;
        logic       g_any;
        logic       out_free;
        t_mode      mode;
    } t_sts;

endpackage

// ----- design/egdrp_req_if.sv -----
`timescale 1ns / 1ps
// Request channel interface.
interface egdrp_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [11:0] rect_x;
    logic signed [11:0] rect_y;
    logic [10:0]        rect_w;
    logic [10:0]        rect_h;
    logic [1:0]         intent;

    modport source (output valid, kind, rect_x, rect_y, rect_w, rect_h, intent,
                    input ready);
    modport sink   (input valid, kind, rect_x, rect_y, rect_w, rect_h, intent,
                    output ready);
endinterface

// ----- design/egdrp_rsp_if.sv -----
`timescale 1ns / 1ps
// Result channel interface.
interface egdrp_rsp_if;
    logic        valid;
    logic        ready;
    logic        pushed;
    logic [2:0]  mode;
    logic [10:0] area_x;
    logic [10:0] area_y;
    logic [10:0] area_w;
    logic [10:0] area_h;
    logic [15:0] flush_total;

    modport source (output valid, pushed, mode, area_x, area_y, area_w, area_h,
                    flush_total, input ready);
    modport sink   (input valid, pushed, mode, area_x, area_y, area_w, area_h,
                    flush_total, output ready);
endinterface

// ----- design/egdrp_cfg_if.sv -----
`timescale 1ns / 1ps
// Configuration write channel interface.
interface egdrp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] ghost_limit;

    modport source (output valid, ghost_limit, input ready);
    modport sink   (input valid, ghost_limit, output ready);
endinterface

// ----- design/egdrp_dp.sv -----
`timescale 1ns / 1ps
// Datapath: box arithmetic, dirty box, tile debt memory with walker, result register.
module egdrp_dp #(
    parameter int DISPLAY_W = egdrp_pkg::DISPLAY_W_DEF,
    parameter int DISPLAY_H = egdrp_pkg::DISPLAY_H_DEF,
    parameter int TILE_SIZE = egdrp_pkg::TILE_SIZE_DEF,
    parameter int TILES_X   = egdrp_pkg::TILES_X_DEF,
    parameter int TILES_Y   = egdrp_pkg::TILES_Y_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  egdrp_pkg::t_cmd    i_cmd,
    output egdrp_pkg::t_sts    o_sts,
    input  logic [2:0]         i_kind,
    input  logic signed [11:0] i_rect_x,
    input  logic signed [11:0] i_rect_y,
    input  logic [10:0]        i_rect_w,
    input  logic [10:0]        i_rect_h,
    input  logic [1:0]         i_intent,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_limit,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_pushed,
    output logic [2:0]         o_mode,
    output logic [10:0]        o_area_x,
    output logic [10:0]        o_area_y,
    output logic [10:0]        o_area_w,
    output logic [10:0]        o_area_h,
    output logic [15:0]        o_flush_total
);

    localparam int NT = TILES_X * TILES_Y;
    localparam int AW = (NT > 1) ? $clog2(NT) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NT - 1);
    localparam egdrp_pkg::t_crd DW_C    = egdrp_pkg::t_crd'(DISPLAY_W);
    localparam egdrp_pkg::t_crd DH_C    = egdrp_pkg::t_crd'(DISPLAY_H);
    localparam egdrp_pkg::t_crd TS_C    = egdrp_pkg::t_crd'(TILE_SIZE);
    localparam egdrp_pkg::t_crd LAST_PX = egdrp_pkg::t_crd'((TILES_X - 1) * TILE_SIZE);
    localparam egdrp_pkg::t_crd LAST_PY = egdrp_pkg::t_crd'((TILES_Y - 1) * TILE_SIZE);
    localparam egdrp_pkg::t_crd ZERO_C  = egdrp_pkg::t_crd'(0);
    localparam egdrp_pkg::t_crd THREE_C = egdrp_pkg::t_crd'(3);
    localparam egdrp_pkg::t_crd ALIGN_M = ~THREE_C;
    localparam logic [21:0] BIG_THR = 22'((DISPLAY_W * DISPLAY_H * 3) / 4);

    // request
    logic [2:0]      r_kind;
    logic [1:0]      r_intent;
    egdrp_pkg::t_crd r_rx, r_ry, r_rw, r_rh;
    // aligned box and clipped area
    egdrp_pkg::t_crd r_ax, r_ay, r_aw, r_ah;
    egdrp_pkg::t_crd r_area_x, r_area_y, r_area_w, r_area_h;
    // dirty box
    logic [11:0]     r_dx, r_dy, r_dw, r_dh;
    egdrp_pkg::t_mode r_mode;
    logic            r_push;
    logic [7:0]      r_limit;
    // walker
    logic            r_wk_busy;
    egdrp_pkg::t_wop r_wop;
    egdrp_pkg::t_crd r_px, r_py;
    logic [AW-1:0]   r_addr;
    logic            r_p_valid, r_p_cov, r_p_last;
    logic [AW-1:0]   r_p_addr;
    egdrp_pkg::t_crd r_p_px, r_p_py;
    logic            r_hit, r_g_any;
    egdrp_pkg::t_crd r_gx0, r_gy0, r_gx1, r_gy1;
    // clearing pass
    logic            r_clr_busy;
    logic [AW-1:0]   r_clr_addr;
    // debt store
    logic [7:0]      r_mem [NT];
    logic [7:0]      r_rd;
    // result
    logic            r_o_valid, r_o_push;
    logic [2:0]      r_o_mode;
    logic [10:0]     r_o_x, r_o_y, r_o_w, r_o_h;
    logic [15:0]     r_count;

    egdrp_pkg::t_crd s_dx, s_dy, s_dw, s_dh;
    egdrp_pkg::t_crd s_src_x, s_src_y, s_src_w, s_src_h;
    logic            s_src_empty;
    egdrp_pkg::t_crd s_al_x, s_al_y, s_al_r, s_al_b;
    egdrp_pkg::t_crd s_c_x0, s_c_y0, s_c_x1, s_c_y1;
    logic            s_c_empty;
    logic            s_dirty_empty, s_area_empty;
    egdrp_pkg::t_crd s_a_r, s_a_b, s_d_r, s_d_b;
    egdrp_pkg::t_crd s_u_x0, s_u_y0, s_u_x1, s_u_y1;
    logic            s_text_clr;
    logic [21:0]     s_apx;
    logic            s_cov;
    logic            s_p_hot;
    egdrp_pkg::t_crd s_t_x1, s_t_y1;
    logic [2:0]      s_amt;
    logic [8:0]      s_sum;
    logic            s_we;
    logic [AW-1:0]   s_wa;
    logic [7:0]      s_wd;
    logic            s_walk_done;

    assign s_dx = egdrp_pkg::t_crd'(r_dx);
    assign s_dy = egdrp_pkg::t_crd'(r_dy);
    assign s_dw = egdrp_pkg::t_crd'(r_dw);
    assign s_dh = egdrp_pkg::t_crd'(r_dh);
    assign s_dirty_empty = (r_dw == 12'd0) || (r_dh == 12'd0);
    assign s_area_empty  = (r_area_w <= ZERO_C) || (r_area_h <= ZERO_C);

    // source box of the alignment step
    always_comb begin
        if (r_kind == egdrp_pkg::KIND_FLUSH) begin
            s_src_x = s_dx;
            s_src_y = s_dy;
            s_src_w = s_dw;
            s_src_h = s_dh;
        end else begin
            s_src_x = r_rx;
            s_src_y = r_ry;
            s_src_w = r_rw;
            s_src_h = r_rh;
        end
    end

    assign s_src_empty = (s_src_w <= ZERO_C) || (s_src_h <= ZERO_C);
    assign s_al_x = s_src_x & ALIGN_M;
    assign s_al_y = s_src_y & ALIGN_M;
    assign s_al_r = (s_src_x + s_src_w + THREE_C) & ALIGN_M;
    assign s_al_b = (s_src_y + s_src_h + THREE_C) & ALIGN_M;

    assign s_c_x0 = (r_ax < ZERO_C) ? ZERO_C : r_ax;
    assign s_c_y0 = (r_ay < ZERO_C) ? ZERO_C : r_ay;
    assign s_c_x1 = (r_ax + r_aw > DW_C) ? DW_C : r_ax + r_aw;
    assign s_c_y1 = (r_ay + r_ah > DH_C) ? DH_C : r_ay + r_ah;
    assign s_c_empty = (r_aw <= ZERO_C) || (r_ah <= ZERO_C) ||
                       (s_c_x1 <= s_c_x0) || (s_c_y1 <= s_c_y0);

    // union of area and dirty box
    assign s_a_r  = r_area_x + r_area_w;
    assign s_a_b  = r_area_y + r_area_h;
    assign s_d_r  = s_dx + s_dw;
    assign s_d_b  = s_dy + s_dh;
    assign s_u_x0 = (r_area_x < s_dx) ? r_area_x : s_dx;
    assign s_u_y0 = (r_area_y < s_dy) ? r_area_y : s_dy;
    assign s_u_x1 = (s_a_r > s_d_r) ? s_a_r : s_d_r;
    assign s_u_y1 = (s_a_b > s_d_b) ? s_a_b : s_d_b;
    assign s_text_clr = !s_dirty_empty &&
                        (s_dx < s_a_r) && (r_area_x < s_d_r) &&
                        (s_dy < s_a_b) && (r_area_y < s_d_b) &&
                        ((s_u_x1 - s_u_x0) == r_area_w) &&
                        ((s_u_y1 - s_u_y0) == r_area_h);

    assign s_apx = 22'(r_area_w[10:0]) * 22'(r_area_h[10:0]);

    // tile coverage for the walker
    always_comb begin
        if (r_wop == egdrp_pkg::WOP_SCAN) begin
            s_cov = (r_px < DW_C) && (r_py < DH_C);
        end else begin
            s_cov = !s_area_empty &&
                    (r_px < s_a_r) && (r_px + TS_C > r_area_x) &&
                    (r_py < s_a_b) && (r_py + TS_C > r_area_y);
        end
    end

    assign s_p_hot = r_p_valid && r_p_cov && (r_rd >= r_limit);
    assign s_t_x1  = (r_p_px + TS_C > DW_C) ? DW_C : r_p_px + TS_C;
    assign s_t_y1  = (r_p_py + TS_C > DH_C) ? DH_C : r_p_py + TS_C;

    always_comb begin
        case (r_mode)
            egdrp_pkg::MODE_GL16: s_amt = 3'd1;
            egdrp_pkg::MODE_DU4:  s_amt = 3'd2;
            default:              s_amt = 3'd4;
        endcase
    end

    assign s_sum = {1'b0, r_rd} + {6'd0, s_amt};

    always_comb begin
        s_we = 1'b0;
        s_wa = r_p_addr;
        s_wd = 8'd0;
        if (r_clr_busy) begin
            s_we = 1'b1;
            s_wa = r_clr_addr;
        end else if (r_p_valid && r_p_cov) begin
            if (r_wop == egdrp_pkg::WOP_CLEAR) begin
                s_we = 1'b1;
            end else if (r_wop == egdrp_pkg::WOP_ADD) begin
                s_we = 1'b1;
                s_wd = s_sum[8] ? 8'hFF : s_sum[7:0];
            end
        end
    end

    assign s_walk_done = r_p_valid && r_p_last;

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_mem[s_wa] <= s_wd;
        end
        r_rd <= r_mem[r_addr];
    end

    // request, boxes and dirty box
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_intent <= i_intent;
            r_rx     <= egdrp_pkg::t_crd'(i_rect_x);
            r_ry     <= egdrp_pkg::t_crd'(i_rect_y);
            r_rw     <= egdrp_pkg::t_crd'(i_rect_w);
            r_rh     <= egdrp_pkg::t_crd'(i_rect_h);
        end
        if (i_cmd.align) begin
            if (r_kind == egdrp_pkg::KIND_INVAL) begin
                r_ax <= s_src_x;
                r_ay <= s_src_y;
                r_aw <= s_src_w;
                r_ah <= s_src_h;
            end else if (s_src_empty) begin
                r_ax <= ZERO_C;
                r_ay <= ZERO_C;
                r_aw <= ZERO_C;
                r_ah <= ZERO_C;
            end else begin
                r_ax <= s_al_x;
                r_ay <= s_al_y;
                r_aw <= s_al_r - s_al_x;
                r_ah <= s_al_b - s_al_y;
            end
        end
        if (i_cmd.clip) begin
            if (r_kind == egdrp_pkg::KIND_FULL) begin
                r_area_x <= ZERO_C;
                r_area_y <= ZERO_C;
                r_area_w <= DW_C;
                r_area_h <= DH_C;
            end else if (s_c_empty) begin
                r_area_x <= ZERO_C;
                r_area_y <= ZERO_C;
                r_area_w <= ZERO_C;
                r_area_h <= ZERO_C;
            end else begin
                r_area_x <= s_c_x0;
                r_area_y <= s_c_y0;
                r_area_w <= s_c_x1 - s_c_x0;
                r_area_h <= s_c_y1 - s_c_y0;
            end
        end else if (i_cmd.ghost_load) begin
            r_area_x <= r_gx0;
            r_area_y <= r_gy0;
            r_area_w <= r_gx1 - r_gx0;
            r_area_h <= r_gy1 - r_gy0;
        end
        if (i_cmd.mode_we) begin
            r_mode <= i_cmd.mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dx    <= 12'd0;
            r_dy    <= 12'd0;
            r_dw    <= 12'(DISPLAY_W);
            r_dh    <= 12'(DISPLAY_H);
            r_limit <= egdrp_pkg::LIMIT_RST;
            r_push  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_limit;
            end
            if (i_cmd.load) begin
                r_push <= 1'b0;
            end else if (i_cmd.push_set) begin
                r_push <= 1'b1;
            end
            if (i_cmd.merge && !s_area_empty) begin
                if (s_dirty_empty) begin
                    r_dx <= r_area_x[11:0];
                    r_dy <= r_area_y[11:0];
                    r_dw <= r_area_w[11:0];
                    r_dh <= r_area_h[11:0];
                end else begin
                    r_dx <= s_u_x0[11:0];
                    r_dy <= s_u_y0[11:0];
                    r_dw <= 12'(s_u_x1 - s_u_x0);
                    r_dh <= 12'(s_u_y1 - s_u_y0);
                end
            end else if (i_cmd.dirty_clear || (i_cmd.dirty_text && s_text_clr)) begin
                r_dx <= 12'd0;
                r_dy <= 12'd0;
                r_dw <= 12'd0;
                r_dh <= 12'd0;
            end
        end
    end

    // clearing pass and tile walker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_wk_busy  <= 1'b0;
            r_p_valid  <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_p_valid <= r_wk_busy;
            if (i_cmd.walk_start) begin
                r_wk_busy <= 1'b1;
            end else if (r_wk_busy && (r_px == LAST_PX) && (r_py == LAST_PY)) begin
                r_wk_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_wop   <= i_cmd.wop;
            r_px    <= ZERO_C;
            r_py    <= ZERO_C;
            r_addr  <= '0;
            r_hit   <= 1'b0;
            r_g_any <= 1'b0;
        end else begin
            if (r_wk_busy) begin
                r_addr <= r_addr + 1'b1;
                if (r_px == LAST_PX) begin
                    r_px <= ZERO_C;
                    r_py <= r_py + TS_C;
                end else begin
                    r_px <= r_px + TS_C;
                end
            end
            if (s_p_hot && (r_wop == egdrp_pkg::WOP_TEST)) begin
                r_hit <= 1'b1;
            end
            if (s_p_hot && (r_wop == egdrp_pkg::WOP_SCAN)) begin
                r_g_any <= 1'b1;
                if (!r_g_any || (r_p_px < r_gx0)) r_gx0 <= r_p_px;
                if (!r_g_any || (r_p_py < r_gy0)) r_gy0 <= r_p_py;
                if (!r_g_any || (s_t_x1 > r_gx1)) r_gx1 <= s_t_x1;
                if (!r_g_any || (s_t_y1 > r_gy1)) r_gy1 <= s_t_y1;
            end
        end
        r_p_cov  <= s_cov;
        r_p_last <= (r_px == LAST_PX) && (r_py == LAST_PY);
        r_p_addr <= r_addr;
        r_p_px   <= r_px;
        r_p_py   <= r_py;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_count   <= 16'd0;
        end else if (i_cmd.finish) begin
            r_o_valid <= 1'b1;
            r_count   <= r_count + {15'd0, r_push};
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_o_push <= r_push;
            r_o_mode <= r_push ? r_mode : egdrp_pkg::MODE_GC16;
            r_o_x    <= r_push ? r_area_x[10:0] : 11'd0;
            r_o_y    <= r_push ? r_area_y[10:0] : 11'd0;
            r_o_w    <= r_push ? r_area_w[10:0] : 11'd0;
            r_o_h    <= r_push ? r_area_h[10:0] : 11'd0;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_pushed      = r_o_push;
    assign o_mode        = r_o_mode;
    assign o_area_x      = r_o_x;
    assign o_area_y      = r_o_y;
    assign o_area_w      = r_o_w;
    assign o_area_h      = r_o_h;
    assign o_flush_total = r_count;

    always_comb begin
        o_sts.clr_busy    = r_clr_busy;
        o_sts.walk_done   = s_walk_done;
        o_sts.kind        = r_kind;
        o_sts.intent      = r_intent;
        o_sts.dirty_empty = s_dirty_empty;
        o_sts.area_empty  = s_area_empty;
        o_sts.big         = s_apx > BIG_THR;
        o_sts.hit         = r_hit;
        o_sts.g_any       = r_g_any;
        o_sts.out_free    = !r_o_valid || i_out_ready;
        o_sts.mode        = r_mode;
    end

endmodule

// ----- design/egdrp_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences the steps of one request over the datapath.
module egdrp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  egdrp_pkg::t_sts i_sts,
    output egdrp_pkg::t_cmd o_cmd,
    input  logic            i_req_valid,
    output logic            o_req_ready
);

    typedef enum logic [10:0] {
        S_CLR    = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_ALIGN  = 11'b000_0000_0100,
        S_CLIP   = 11'b000_0000_1000,
        S_PLAN   = 11'b000_0001_0000,
        S_TEST   = 11'b000_0010_0000,
        S_PICK   = 11'b000_0100_0000,
        S_CHARGE = 11'b000_1000_0000,
        S_SCAN   = 11'b001_0000_0000,
        S_GHOST  = 11'b010_0000_0000,
        S_FINISH = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    egdrp_pkg::t_mode s_mode_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                if (!i_sts.clr_busy) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ALIGN;
                end
            end
            S_ALIGN: begin
                o_cmd.align = 1'b1;
                n_state     = S_CLIP;
            end
            S_CLIP: begin
                o_cmd.clip = 1'b1;
                n_state    = S_PLAN;
            end
            S_PLAN: begin
                case (i_sts.kind)
                    egdrp_pkg::KIND_INVAL: begin
                        o_cmd.merge = 1'b1;
                        n_state     = S_FINISH;
                    end
                    egdrp_pkg::KIND_FLUSH: begin
                        if (i_sts.dirty_empty) begin
                            n_state = S_FINISH;
                        end else if (i_sts.intent == egdrp_pkg::INTENT_CLEAN || i_sts.big) begin
                            o_cmd.mode_we = 1'b1;
                            o_cmd.mode    = egdrp_pkg::MODE_GC16;
                            n_state       = S_CHARGE;
                        end else begin
                            n_state = S_TEST;
                        end
                    end
                    egdrp_pkg::KIND_TEXT: begin
                        n_state = i_sts.area_empty ? S_FINISH : S_TEST;
                    end
                    egdrp_pkg::KIND_FULL: begin
                        o_cmd.mode_we = 1'b1;
                        o_cmd.mode    = egdrp_pkg::MODE_GC16;
                        n_state       = S_CHARGE;
                    end
                    egdrp_pkg::KIND_GHOST: begin
                        n_state = S_SCAN;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_TEST: begin
                if (i_sts.walk_done) n_state = S_PICK;
            end
            S_PICK: begin
                o_cmd.mode_we = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.mode = egdrp_pkg::MODE_GC16;
                end else if (i_sts.kind == egdrp_pkg::KIND_TEXT) begin
                    o_cmd.mode = egdrp_pkg::MODE_DU4;
                end else if (i_sts.intent == egdrp_pkg::INTENT_ANIM) begin
                    o_cmd.mode = egdrp_pkg::MODE_A2;
                end else if (i_sts.intent == egdrp_pkg::INTENT_TEXT) begin
                    o_cmd.mode = egdrp_pkg::MODE_DU4;
                end else begin
                    o_cmd.mode = egdrp_pkg::MODE_GL16;
                end
                n_state = S_CHARGE;
            end
            S_SCAN: begin
                if (i_sts.walk_done) n_state = S_GHOST;
            end
            S_GHOST: begin
                if (i_sts.g_any) begin
                    o_cmd.ghost_load = 1'b1;
                    o_cmd.mode_we    = 1'b1;
                    o_cmd.mode       = egdrp_pkg::MODE_GC16;
                    n_state          = S_CHARGE;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_CHARGE: begin
                if (i_sts.walk_done) begin
                    // a flush or full refresh empties the dirty box
                    o_cmd.dirty_clear = (i_sts.kind == egdrp_pkg::KIND_FLUSH) ||
                                        (i_sts.kind == egdrp_pkg::KIND_FULL);
                    o_cmd.dirty_text  = (i_sts.kind == egdrp_pkg::KIND_TEXT);
                    n_state           = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase

        // start a tile walk on entry to a walking state
        s_mode_now = o_cmd.mode_we ? o_cmd.mode : i_sts.mode;
        if (n_state != r_state) begin
            case (n_state)
                S_TEST: begin
                    o_cmd.walk_start = 1'b1;
                    o_cmd.wop        = egdrp_pkg::WOP_TEST;
                end
                S_SCAN: begin
                    o_cmd.walk_start = 1'b1;
                    o_cmd.wop        = egdrp_pkg::WOP_SCAN;
                end
                S_CHARGE: begin
                    o_cmd.walk_start = 1'b1;
                    o_cmd.push_set   = 1'b1;
                    o_cmd.wop        = (s_mode_now == egdrp_pkg::MODE_GC16) ?
                                       egdrp_pkg::WOP_CLEAR : egdrp_pkg::WOP_ADD;
                end
                default: begin
                    o_cmd.walk_start = 1'b0;
                end
            endcase
        end
    end

endmodule

// ----- design/epaper_ghost_debt_refresh_policy_unit.sv -----
`timescale 1ns / 1ps
// Top level of the e-paper ghost-debt refresh policy unit.
// After reset the unit clears its tile debt memory, one tile a cycle, before
// it takes the first request. One request is worked at a time. Invalidate,
// unknown kinds and flushes that push nothing make no pass over the debt
// memory; each pass walks every tile through its one read port and its one
// write port. A plain or text flush with a limit test and a ghost refresh
// that finds a tile at the limit make two passes. A flush with clean intent
// or a large area, a full refresh and a ghost refresh that finds nothing
// make one. The next request is taken while a result still waits on the
// result port.
module epaper_ghost_debt_refresh_policy_unit #(
    parameter int DISPLAY_W = egdrp_pkg::DISPLAY_W_DEF,
    parameter int DISPLAY_H = egdrp_pkg::DISPLAY_H_DEF,
    parameter int TILE_SIZE = egdrp_pkg::TILE_SIZE_DEF,
    parameter int TILES_X   = egdrp_pkg::TILES_X_DEF,
    parameter int TILES_Y   = egdrp_pkg::TILES_Y_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    egdrp_req_if.sink    i_req,
    egdrp_rsp_if.source  o_rsp,
    egdrp_cfg_if.sink    i_cfg
);

    egdrp_pkg::t_cmd s_cmd;
    egdrp_pkg::t_sts s_sts;

    assign i_cfg.ready = 1'b1;

    egdrp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sts       (s_sts),
        .o_cmd       (s_cmd),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready)
    );

    egdrp_dp #(
        .DISPLAY_W (DISPLAY_W),
        .DISPLAY_H (DISPLAY_H),
        .TILE_SIZE (TILE_SIZE),
        .TILES_X   (TILES_X),
        .TILES_Y   (TILES_Y)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (s_cmd),
        .o_sts         (s_sts),
        .i_kind        (i_req.kind),
        .i_rect_x      (i_req.rect_x),
        .i_rect_y      (i_req.rect_y),
        .i_rect_w      (i_req.rect_w),
        .i_rect_h      (i_req.rect_h),
        .i_intent      (i_req.intent),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_limit   (i_cfg.ghost_limit),
        .o_out_valid   (o_rsp.valid),
        .i_out_ready   (o_rsp.ready),
        .o_pushed      (o_rsp.pushed),
        .o_mode        (o_rsp.mode),
        .o_area_x      (o_rsp.area_x),
        .o_area_y      (o_rsp.area_y),
        .o_area_w      (o_rsp.area_w),
        .o_area_h      (o_rsp.area_h),
        .o_flush_total (o_rsp.flush_total)
    );

    // the update count moves by one exactly for each pushed result
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.ready) |=> (!o_rsp.valid ||
            (o_rsp.flush_total == $past(o_rsp.flush_total) + {15'd0, o_rsp.pushed})))
        else $error("flush_total out of step with pushed results");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.pushed) |->
            (o_rsp.area_w == 11'd0 && o_rsp.area_h == 11'd0 &&
             o_rsp.mode == egdrp_pkg::MODE_GC16))
        else $error("result without push carries an area");

    a_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.pushed) |->
            (({1'b0, o_rsp.area_x} + {1'b0, o_rsp.area_w} <= 12'(DISPLAY_W)) &&
             ({1'b0, o_rsp.area_y} + {1'b0, o_rsp.area_h} <= 12'(DISPLAY_H))))
        else $error("pushed area leaves the screen");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the ghost-debt refresh policy unit with its own ledger model.
module testbench;
    import egdrp_pkg::*;

    localparam int SCR_W     = DISPLAY_W_DEF;
    localparam int SCR_H     = DISPLAY_H_DEF;
    localparam int TILE      = TILE_SIZE_DEF;
    localparam int TX        = TILES_X_DEF;
    localparam int TY        = TILES_Y_DEF;
    localparam int MAX_CYCLE = 4000000;

    typedef struct {
        logic [2:0]         kind;
        logic signed [11:0] rx;
        logic signed [11:0] ry;
        logic [10:0]        rw;
        logic [10:0]        rh;
        logic [1:0]         intent;
    } req_t;

    typedef struct {
        logic        pushed;
        t_mode       mode;
        logic [10:0] ax;
        logic [10:0] ay;
        logic [10:0] aw;
        logic [10:0] ah;
        logic [15:0] total;
    } upd_t;

    typedef struct { int x, y, w, h; } box_t;

    logic i_clk;
    logic i_rst_n;

    egdrp_req_if req_ch ();
    egdrp_rsp_if rsp_ch ();
    egdrp_cfg_if cfg_ch ();

    epaper_ghost_debt_refresh_policy_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // ledger copy
    logic [7:0]  debt [TX*TY];
    box_t        dirty;
    logic [15:0] n_updates;
    logic [7:0]  limit_reg;

    req_t pending_reqs[$];
    upd_t expected_updates[$];
    int   send_idle, recv_idle;
    int   errors, cycles, accepted, pushes, gc16_count;
    int   kind_seen [8];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit is_empty(box_t b);
        return b.w <= 0 || b.h <= 0;
    endfunction

    function automatic box_t clip_box(box_t b);
        box_t r = '{0, 0, 0, 0};
        int x0, y0, x1, y1;
        x0 = b.x < 0 ? 0 : b.x;
        y0 = b.y < 0 ? 0 : b.y;
        x1 = b.x + b.w;
        y1 = b.y + b.h;
        if (x1 > SCR_W) x1 = SCR_W;
        if (y1 > SCR_H) y1 = SCR_H;
        if (is_empty(b) || x1 <= x0 || y1 <= y0) return r;
        r = '{x0, y0, x1 - x0, y1 - y0};
        return r;
    endfunction

    function automatic int down4(int v);
        return v - (((v % 4) + 4) % 4);
    endfunction

    function automatic box_t align_box(box_t b);
        box_t r = '{0, 0, 0, 0};
        if (is_empty(b)) return r;
        r.x = down4(b.x);
        r.y = down4(b.y);
        r.w = down4(b.x + b.w + 3) - r.x;
        r.h = down4(b.y + b.h + 3) - r.y;
        return r;
    endfunction

    function automatic box_t merge_box(box_t a, box_t b);
        box_t r;
        int ar, br, ab, bb;
        if (is_empty(a)) return b;
        if (is_empty(b)) return a;
        ar = a.x + a.w; br = b.x + b.w; ab = a.y + a.h; bb = b.y + b.h;
        r.x = a.x < b.x ? a.x : b.x;
        r.y = a.y < b.y ? a.y : b.y;
        r.w = (ar > br ? ar : br) - r.x;
        r.h = (ab > bb ? ab : bb) - r.y;
        return r;
    endfunction

    // walk the tiles under an on-screen area: clear, add or test against the limit
    function automatic bit walk_tiles(box_t a, t_wop op, int amt);
        int tx0, ty0, tx1, ty1, n;
        if (is_empty(a)) return 1'b0;
        tx0 = a.x / TILE;
        ty0 = a.y / TILE;
        tx1 = (a.x + a.w + TILE - 1) / TILE;
        ty1 = (a.y + a.h + TILE - 1) / TILE;
        if (tx1 > TX) tx1 = TX;
        if (ty1 > TY) ty1 = TY;
        for (int ty = ty0; ty < ty1; ty++) begin
            for (int tx = tx0; tx < tx1; tx++) begin
                if (op == WOP_CLEAR) begin
                    debt[ty*TX + tx] = 8'd0;
                end else if (op == WOP_ADD) begin
                    n = int'(debt[ty*TX + tx]) + amt;
                    debt[ty*TX + tx] = n > 255 ? 8'd255 : 8'(n);
                end else if (debt[ty*TX + tx] >= limit_reg) begin
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic void charge_area(box_t a, t_mode m);
        if (m == MODE_GC16) void'(walk_tiles(a, WOP_CLEAR, 0));
        else void'(walk_tiles(a, WOP_ADD, m == MODE_GL16 ? 1 : m == MODE_DU4 ? 2 : 4));
    endfunction

    function automatic void set_dirty(box_t b);
        if (is_empty(b)) b = '{0, 0, 0, 0};
        dirty = b;
    endfunction

    function automatic upd_t predict_update(req_t q);
        box_t r, area, d, u, g, t;
        bit   pushed;
        t_mode m;
        upd_t res;
        area = '{0, 0, 0, 0};
        pushed = 1'b0;
        m = MODE_GC16;
        r = '{int'(q.rx), int'(q.ry), int'(q.rw), int'(q.rh)};
        case (q.kind)
            KIND_INVAL: begin
                t = clip_box(r);
                if (!is_empty(t)) set_dirty(merge_box(dirty, t));
            end
            KIND_FLUSH: begin
                if (!is_empty(dirty)) begin
                    area = clip_box(align_box(dirty));
                    if (q.intent == INTENT_CLEAN || walk_tiles(area, WOP_TEST, 0)
                            || area.w * area.h > (SCR_W * SCR_H * 3) / 4)
                        m = MODE_GC16;
                    else if (q.intent == INTENT_ANIM)
                        m = MODE_A2;
                    else if (q.intent == INTENT_TEXT)
                        m = MODE_DU4;
                    else
                        m = MODE_GL16;
                    charge_area(area, m);
                    set_dirty('{0, 0, 0, 0});
                    pushed = 1'b1;
                end
            end
            KIND_TEXT: begin
                area = clip_box(align_box(r));
                if (!is_empty(area)) begin
                    d = dirty;
                    m = walk_tiles(area, WOP_TEST, 0) ? MODE_GC16 : MODE_DU4;
                    charge_area(area, m);
                    pushed = 1'b1;
                    u = merge_box(area, d);
                    // drop the dirty box once the text area swallows it
                    if (!is_empty(d) && d.x < area.x + area.w && area.x < d.x + d.w &&
                            d.y < area.y + area.h && area.y < d.y + d.h &&
                            u.w == area.w && u.h == area.h)
                        set_dirty('{0, 0, 0, 0});
                end
            end
            KIND_FULL: begin
                area = '{0, 0, SCR_W, SCR_H};
                m = MODE_GC16;
                void'(walk_tiles(area, WOP_CLEAR, 0));
                set_dirty('{0, 0, 0, 0});
                pushed = 1'b1;
            end
            KIND_GHOST: begin
                g = '{0, 0, 0, 0};
                for (int ty = 0; ty < TY; ty++)
                    for (int tx = 0; tx < TX; tx++)
                        if (debt[ty*TX + tx] >= limit_reg)
                            g = merge_box(g, clip_box('{tx*TILE, ty*TILE, TILE, TILE}));
                if (!is_empty(g)) begin
                    area = g;
                    m = MODE_GC16;
                    void'(walk_tiles(area, WOP_CLEAR, 0));
                    pushed = 1'b1;
                end
            end
            default: ;
        endcase
        if (pushed) n_updates = n_updates + 16'd1;
        else begin
            area = '{0, 0, 0, 0};
            m = MODE_GC16;
        end
        res.pushed = pushed;
        res.mode   = m;
        res.ax     = 11'(area.x);
        res.ay     = 11'(area.y);
        res.aw     = 11'(area.w);
        res.ah     = 11'(area.h);
        res.total  = n_updates;
        return res;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        req_t q;
        upd_t e;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                q = '{req_ch.kind, req_ch.rect_x, req_ch.rect_y, req_ch.rect_w,
                      req_ch.rect_h, req_ch.intent};
                e = predict_update(q);
                expected_updates.push_back(e);
                accepted++;
                kind_seen[q.kind]++;
                if (e.pushed) pushes++;
                if (e.pushed && e.mode == MODE_GC16) gc16_count++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
                    q = pending_reqs.pop_front();
                    req_ch.kind   <= q.kind;
                    req_ch.rect_x <= q.rx;
                    req_ch.rect_y <= q.ry;
                    req_ch.rect_w <= q.rw;
                    req_ch.rect_h <= q.rh;
                    req_ch.intent <= q.intent;
                    req_ch.valid  <= 1'b1;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        upd_t e;
        cycles++;
        if (cycles >= MAX_CYCLE) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_updates.size() == 0) begin
                    $error("update with no request outstanding");
                    errors++;
                end else begin
                    e = expected_updates.pop_front();
                    if (rsp_ch.pushed !== e.pushed) begin
                        $error("pushed: expected %0d, got %0d", e.pushed, rsp_ch.pushed);
                        errors++;
                    end
                    if (rsp_ch.mode !== e.mode) begin
                        $error("mode: expected %0d, got %0d", e.mode, rsp_ch.mode);
                        errors++;
                    end
                    if (rsp_ch.area_x !== e.ax) begin
                        $error("area_x: expected %0d, got %0d", e.ax, rsp_ch.area_x);
                        errors++;
                    end
                    if (rsp_ch.area_y !== e.ay) begin
                        $error("area_y: expected %0d, got %0d", e.ay, rsp_ch.area_y);
                        errors++;
                    end
                    if (rsp_ch.area_w !== e.aw) begin
                        $error("area_w: expected %0d, got %0d", e.aw, rsp_ch.area_w);
                        errors++;
                    end
                    if (rsp_ch.area_h !== e.ah) begin
                        $error("area_h: expected %0d, got %0d", e.ah, rsp_ch.area_h);
                        errors++;
                    end
                    if (rsp_ch.flush_total !== e.total) begin
                        $error("flush_total: expected %0d, got %0d", e.total,
                               rsp_ch.flush_total);
                        errors++;
                    end
                end
            end
            rsp_ch.ready <= $urandom_range(99) >= recv_idle;
        end
    end

    function automatic req_t make_req(logic [2:0] k, int x, int y, int w, int h,
                                      logic [1:0] it);
        req_t q;
        q.kind = k;
        q.rx = 12'(x);
        q.ry = 12'(y);
        q.rw = 11'(w);
        q.rh = 11'(h);
        q.intent = it;
        return q;
    endfunction

    function automatic req_t random_req();
        int    p;
        req_t  q;
        logic [2:0] k;
        p = $urandom_range(99);
        if (p < 36) k = KIND_INVAL;
        else if (p < 62) k = KIND_FLUSH;
        else if (p < 76) k = KIND_TEXT;
        else if (p < 80) k = KIND_FULL;
        else if (p < 96) k = KIND_GHOST;
        else k = 3'($urandom_range(5, 7));
        if ($urandom_range(3) != 0)
            q = make_req(k, $urandom_range(0, 580) - 20, $urandom_range(0, 1000) - 20,
                         $urandom_range(0, 180), $urandom_range(0, 260),
                         2'($urandom_range(3)));
        else
            q = make_req(k, $urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 2047), $urandom_range(0, 2047),
                         2'($urandom_range(3)));
        return q;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_ch.valid || expected_updates.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [7:0] v);
        @(posedge i_clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.ghost_limit <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        limit_reg = v;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_random(logic [7:0] lim, int s_idle, int r_idle, int n);
        write_limit(lim);
        send_idle = s_idle;
        recv_idle = r_idle;
        for (int i = 0; i < n; i++) pending_reqs.push_back(random_req());
        wait_drained();
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_INVAL;
        req_ch.rect_x = '0;
        req_ch.rect_y = '0;
        req_ch.rect_w = '0;
        req_ch.rect_h = '0;
        req_ch.intent = INTENT_CLEAN;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.ghost_limit = LIMIT_RST;
        for (int i = 0; i < TX*TY; i++) debt[i] = 8'd0;
        dirty = '{0, 0, SCR_W, SCR_H};
        n_updates = '0;
        limit_reg = LIMIT_RST;
        send_idle = 6;
        recv_idle = 84;
        errors = 0; cycles = 0; accepted = 0; pushes = 0; gc16_count = 0;
        for (int i = 0; i < 8; i++) kind_seen[i] = 0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset dirty box, empty and off-screen rectangles, each intent
        pending_reqs.push_back(make_req(KIND_FLUSH, 0, 0, 0, 0, 2'd3));
        pending_reqs.push_back(make_req(KIND_FLUSH, 0, 0, 0, 0, 2'd1));
        pending_reqs.push_back(make_req(KIND_INVAL, 10, 10, 0, 40, 2'd0));
        pending_reqs.push_back(make_req(KIND_INVAL, -2048, -2048, 2047, 2047, 2'd0));
        pending_reqs.push_back(make_req(KIND_INVAL, 2047, 2047, 2047, 2047, 2'd0));
        pending_reqs.push_back(make_req(KIND_INVAL, 3, 5, 29, 31, 2'd0));
        pending_reqs.push_back(make_req(KIND_FLUSH, 0, 0, 0, 0, 2'd1));
        pending_reqs.push_back(make_req(KIND_INVAL, 537, 957, 100, 100, 2'd0));
        pending_reqs.push_back(make_req(KIND_FLUSH, 0, 0, 0, 0, 2'd2));
        pending_reqs.push_back(make_req(KIND_INVAL, 40, 40, 60, 60, 2'd0));
        pending_reqs.push_back(make_req(KIND_FLUSH, 0, 0, 0, 0, 2'd3));
        pending_reqs.push_back(make_req(KIND_INVAL, 40, 40, 60, 60, 2'd0));
        pending_reqs.push_back(make_req(KIND_FLUSH, 0, 0, 0, 0, 2'd0));
        pending_reqs.push_back(make_req(KIND_INVAL, 50, 50, 10, 10, 2'd0));
        pending_reqs.push_back(make_req(KIND_TEXT, 33, 33, 100, 100, 2'd0));
        pending_reqs.push_back(make_req(KIND_TEXT, -5, -5, 0, 9, 2'd0));
        pending_reqs.push_back(make_req(KIND_TEXT, -100, -100, 2047, 2047, 2'd0));
        pending_reqs.push_back(make_req(KIND_GHOST, 0, 0, 0, 0, 2'd0));
        pending_reqs.push_back(make_req(KIND_FULL, 0, 0, 0, 0, 2'd0));
        pending_reqs.push_back(make_req(3'd5, -1, -1, 2047, 2047, 2'd3));
        pending_reqs.push_back(make_req(3'd6, 0, 0, 1, 1, 2'd1));
        pending_reqs.push_back(make_req(3'd7, 2047, 0, 0, 2047, 2'd2));
        wait_drained();

        // heavy debt on one strip so ghost and limit hits happen at a low limit
        write_limit(8'd1);
        for (int i = 0; i < 3; i++) begin
            pending_reqs.push_back(make_req(KIND_INVAL, 100, 200, 70, 40, 2'd0));
            pending_reqs.push_back(make_req(KIND_FLUSH, 0, 0, 0, 0, 2'd1));
        end
        pending_reqs.push_back(make_req(KIND_TEXT, 96, 196, 80, 50, 2'd0));
        pending_reqs.push_back(make_req(KIND_GHOST, 0, 0, 0, 0, 2'd0));
        wait_drained();

        run_random(8'd1, 6, 84, 300);
        run_random(8'd255, 84, 6, 300);
        run_random(8'd0, 0, 0, 100);
        run_random(8'd8, 0, 0, 250);

        $display("Requests: %0d (invalidate %0d, flush %0d, text %0d, full %0d, ghost %0d)",
                 accepted, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
                 kind_seen[4]);
        $display("Panel updates: %0d, of which GC16 %0d; limits 16, 1, 255, 0, 8 used",
                 pushes, gc16_count);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
